[hw/rtl/cds_pkg.sv]
package cds_pkg;

	localparam int FRAC_BITS = 16;

	localparam logic [31:0] GAIN_RESET   = 32'(64'd1 << FRAC_BITS);
	localparam logic [31:0] OFFSET_RESET = 32'd0;

	// Largest calibrated value whose integer part still fits in 16 bits
	localparam logic [31:0] STATE_CAP = (FRAC_BITS > 16) ? 32'hFFFF_FFFF :
		32'((64'd65536 << FRAC_BITS) - 64'd1);

	// Smoothing weights, Q0.16, sum to 1.0
	localparam logic [16:0] W_NEW   = 17'd19661;
	localparam logic [16:0] W_OLD   = 17'd45875;
	localparam logic [15:0] W_ROUND = 16'd32768;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;

endpackage

[hw/rtl/calibrated_distance_smoother_top.sv]
// Channel   Handshake              Payload
// input     in_valid / in_ready    raw_range[15:0], reading_ready
// output    out_valid / out_ready  distance_out[15:0]
// config    cfg_we (no wait)       cfg_index[1:0], cfg_data[31:0]
//
// One shared 33x17 signed multiplier is stepped by a small sequencer; the block
// takes one reading at a time and in_ready is low while it works.
// Reading not ready or zero: straight to output. First reading while the average is
// zero: calibrate and clamp, then output. Otherwise three multiplier passes and a sum.
// A result stalled at the output register holds the sequencer before its final load.
// Reset clears gain to 1.0, offset and the average to zero.
module calibrated_distance_smoother_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [15:0]                    raw_range,
	input  logic                           reading_ready,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [15:0]                    distance_out,
	input  logic                           cfg_we,
	input  logic [cds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CAL   = 3'd1;
	localparam logic [2:0] S_CLAMP = 3'd2;
	localparam logic [2:0] S_MNEW  = 3'd3;
	localparam logic [2:0] S_MOLD  = 3'd4;
	localparam logic [2:0] S_SUM   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]         state_q;
	logic [31:0]        gain_q;
	logic [31:0]        offset_q;
	logic [31:0]        smooth_q;
	logic [31:0]        actual_q;
	logic [15:0]        raw_q;
	logic [15:0]        res_q;
	logic [47:0]        acc_q;
	logic               out_valid_q;
	logic [15:0]        distance_q;

	logic signed [32:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [49:0] mul_q;
	logic [50:0]        cal_sum;
	logic [31:0]        actual;
	logic [48:0]        ema_sum;
	logic [31:0]        ema_new;

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign distance_out = distance_q;

	always_comb begin
		unique case (state_q)
			S_CAL: begin
				mul_a = $signed({gain_q[31], gain_q});
				mul_b = $signed({1'b0, raw_q});
			end
			S_MNEW: begin
				mul_a = $signed({1'b0, actual_q});
				mul_b = $signed(cds_pkg::W_NEW);
			end
			S_MOLD: begin
				mul_a = $signed({1'b0, smooth_q});
				mul_b = $signed(cds_pkg::W_OLD);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// gain*raw + offset, then clamp to [0, cap]
	always_comb begin
		cal_sum = {mul_q[49], mul_q} + {{19{offset_q[31]}}, offset_q};
		priority if (cal_sum[50]) begin
			actual = '0;
		end else if (cal_sum > {19'd0, cds_pkg::STATE_CAP}) begin
			actual = cds_pkg::STATE_CAP;
		end else begin
			actual = cal_sum[31:0];
		end
	end

	// round half up: add 0.5 before dropping 16 fraction bits
	assign ema_sum = {1'b0, acc_q} + {1'b0, mul_q[47:0]} + {33'd0, cds_pkg::W_ROUND};
	assign ema_new = ema_sum[47:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= cds_pkg::GAIN_RESET;
			offset_q <= cds_pkg::OFFSET_RESET;
		end else if (cfg_we) begin
			if (cfg_index == cds_pkg::REG_GAIN) begin
				gain_q <= cfg_data;
			end else if (cfg_index == cds_pkg::REG_OFFSET) begin
				offset_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			smooth_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						// drop readings that are not ready or zero
						if (!reading_ready || raw_range == 16'd0) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_CAL;
						end
					end
				end
				S_CAL: begin
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					if (smooth_q == 32'd0) begin
						smooth_q <= actual;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_MNEW;
					end
				end
				S_MNEW: begin
					state_q <= S_MOLD;
				end
				S_MOLD: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					smooth_q <= ema_new;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			raw_q <= raw_range;
			res_q <= '0;
		end
		if (state_q == S_CLAMP) begin
			actual_q <= actual;
			if (smooth_q == 32'd0) begin
				res_q <= 16'(actual >> cds_pkg::FRAC_BITS);
			end
		end
		if (state_q == S_MOLD) begin
			acc_q <= mul_q[47:0];
		end
		if (state_q == S_SUM) begin
			res_q <= 16'(ema_new >> cds_pkg::FRAC_BITS);
		end
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			distance_q <= res_q;
		end
	end

endmodule

[hw/rtl/cds_checker.sv]
module cds_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [15:0]                    raw_range,
	input logic                           reading_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [15:0]                    distance_out
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance_out))
		else $error("output changed while stalled");

	// one transaction at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");

	// a dropped reading passes through the output state and gives zero when the output is free
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid && (!reading_ready || raw_range == 16'd0)
		|=> ##1 out_valid && distance_out == 16'd0)
		else $error("dropped reading did not give zero");

endmodule

bind calibrated_distance_smoother_top cds_checker u_cds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.raw_range     (raw_range),
	.reading_ready (reading_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.distance_out  (distance_out)
);

[sim/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [cds_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [cds_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 16;

	class distance_scoreboard;
		logic signed [31:0] gain_q;
		logic signed [31:0] offset_q;
		logic [31:0] smoothed;
		logic [15:0] pending_distances[$];
		int errors;

		function new();
			gain_q = 32'(64'd1 << cds_pkg::FRAC_BITS);
			offset_q = '0;
			smoothed = '0;
			errors = 0;
		endfunction

		function void set_register(logic [cds_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				cds_pkg::REG_GAIN: gain_q = data;
				cds_pkg::REG_OFFSET: offset_q = data;
				default: ;
			endcase
		endfunction

		function logic [31:0] calibrated(logic [15:0] raw);
			longint lin;
			logic [63:0] cap;
			cap = (64'd65536 << cds_pkg::FRAC_BITS) - 64'd1;
			if (cap > 64'hFFFF_FFFF)
				cap = 64'hFFFF_FFFF;
			lin = longint'(raw) * longint'(gain_q) + longint'(offset_q);
			if (lin < 0)
				return '0;
			if (64'(lin) > cap)
				return cap[31:0];
			return lin[31:0];
		endfunction

		function void note_reading(logic [15:0] raw, logic rdy);
			logic [31:0] fresh;
			logic [63:0] blend;
			logic [31:0] whole;
			if (!rdy || raw == 16'd0) begin
				pending_distances.push_back(16'd0);
				return;
			end
			fresh = calibrated(raw);
			if (smoothed == 32'd0) begin
				smoothed = fresh;
			end else begin
				// 0.3 new + 0.7 old in Q0.16, round half up
				blend = 64'(fresh) * 64'd19661 + 64'(smoothed) * 64'd45875 + 64'd32768;
				smoothed = blend[47:16];
			end
			whole = smoothed >> cds_pkg::FRAC_BITS;
			pending_distances.push_back(whole[15:0]);
		endfunction

		function void check_distance(logic [15:0] got);
			logic [15:0] want;
			if (pending_distances.size() == 0) begin
				$display("%0t: unexpected distance_out %0d", $time, got);
				errors++;
				return;
			end
			want = pending_distances.pop_front();
			if (got !== want) begin
				$display("%0t: distance_out mismatch: expected %0d, actual %0d",
					$time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [15:0] raw_range;
	logic reading_ready;
	logic out_valid;
	logic out_ready;
	logic [15:0] distance_out;
	logic cfg_we;
	logic [cds_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	distance_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int recv_hold;

	calibrated_distance_smoother_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_range(raw_range),
		.reading_ready(reading_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.distance_out(distance_out),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Output side: random stalls, or a long hold-off when requested
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (recv_hold > 0) begin
				out_ready = 1'b0;
				recv_hold--;
			end else begin
				out_ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_distance(distance_out);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** calibrated_distance_smoother_top: FAILED **");
		$finish;
	end

	task automatic send_reading(input logic [15:0] raw, input logic rdy);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid = 1'b1;
		raw_range = raw;
		reading_ready = rdy;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_reading(raw, rdy);
		@(negedge clk);
	endtask

	// Hold the input until every result is back and the block is idle
	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending_distances.size() != 0 || !in_ready)
			@(negedge clk);
	endtask

	task automatic write_register(input logic [cds_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_register(idx, data);
	endtask

	task automatic configure(input logic [31:0] g, input logic [31:0] o);
		drain();
		write_register(cds_pkg::REG_GAIN, g);
		write_register(cds_pkg::REG_OFFSET, o);
	endtask

	task automatic pick_setting(output logic [31:0] g, output logic [31:0] o);
		logic [31:0] edges[5];
		int off;
		edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000};
		case ($urandom_range(3))
			0: begin
				g = 32'(57344 + $urandom_range(16384));
				off = int'($urandom_range(13107200)) - 6553600;
				o = 32'(off);
			end
			1: begin
				g = $urandom;
				o = $urandom;
			end
			2: begin
				g = edges[$urandom_range(4)];
				o = edges[$urandom_range(3)];
			end
			default: begin
				g = 32'($urandom_range(65535));
				o = -32'($urandom_range(1 << 24));
			end
		endcase
	endtask

	task automatic random_readings(input int count);
		logic [15:0] raw;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 4)
				raw = 16'd0;
			else if (pick < 8)
				raw = 16'hFFFF;
			else if (pick < 12)
				raw = 16'($urandom_range(1, 15));
			else
				raw = 16'($urandom);
			// pause the sender now and then until all results are back
			if ($urandom_range(99) < 2)
				drain();
			send_reading(raw, $urandom_range(99) < 85);
		end
	endtask

	initial begin
		int send_pcts[4];
		int stall_pcts[4];
		logic [31:0] g;
		logic [31:0] o;
		send_pcts = '{0, 52, 0, 18};
		stall_pcts = '{0, 0, 52, 18};
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 0;
		in_valid = 1'b0;
		raw_range = '0;
		reading_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = cds_pkg::REG_GAIN;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset calibration; not-ready and zero readings leave the average alone
		send_reading(16'd0, 1'b1);
		send_reading(16'hFFFF, 1'b0);
		send_reading(16'd0, 1'b0);
		// Negative calibrated values clamp to zero and load a zero average
		configure(32'h8000_0000, 32'h8000_0000);
		send_reading(16'hFFFF, 1'b1);
		send_reading(16'd1, 1'b1);
		configure(32'h0, 32'h0);
		send_reading(16'd1, 1'b1);
		// First real value loads the average directly, then smoothing starts
		configure(32'(64'd1 << cds_pkg::FRAC_BITS), 32'h0);
		send_reading(16'd1, 1'b1);
		send_reading(16'hFFFF, 1'b1);
		send_reading(16'h8000, 1'b1);
		// Saturate at the top
		configure(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_reading(16'hFFFF, 1'b1);
		send_reading(16'd1, 1'b1);
		send_reading(16'hFFFF, 1'b1);
		send_reading(16'hFFFF, 1'b1);
		configure(32'h0, 32'h7FFF_FFFF);
		send_reading(16'h5555, 1'b1);
		configure(32'hFFFF_0000, 32'h7FFF_FFFF);
		send_reading(16'hAAAA, 1'b1);
		send_reading(16'h5555, 1'b1);
		send_reading(16'h0001, 1'b0);
		// Spare indexes must not disturb the calibration
		drain();
		write_register(REG_SPARE_2, 32'hFFFF_FFFF);
		write_register(REG_SPARE_3, 32'h5A5A_A5A5);
		send_reading(16'd1000, 1'b1);
		send_reading(16'hFFFF, 1'b1);

		for (int p = 0; p < 8; p++) begin
			pick_setting(g, o);
			configure(g, o);
			write_register((p % 2) ? REG_SPARE_3 : REG_SPARE_2, $urandom);
			send_idle_pct = send_pcts[p % 4];
			recv_stall_pct = stall_pcts[p % 4];
			random_readings(78);
			if (p == 0) begin
				// Back-pressure: block fills and stalls its input
				drain();
				send_idle_pct = 0;
				recv_hold = HOLD_OFF_CYCLES;
				random_readings(24);
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending_distances.size() == 0) begin
			$display("** calibrated_distance_smoother_top: PASSED **");
		end else begin
			$display("** calibrated_distance_smoother_top: FAILED **");
		end
		$finish;
	end

endmodule
